// ----- src/json_byte_tokenizer_core_macros.svh -----
// Assertion macros for the JSON byte tokenizer checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef JSON_BYTE_TOKENIZER_CORE_MACROS_SVH
`define JSON_BYTE_TOKENIZER_CORE_MACROS_SVH

// same-cycle implication
`define JBT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JBT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/jbt_pkg.sv -----
// Shared types, token codes and character helpers for the JSON byte tokenizer.
// No dependencies.
package jbt_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } byte_beat_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] value_start;
        logic [15:0] value_length;
        logic        last_of_run;
    } token_beat_t;

    localparam logic [3:0] TK_END    = 4'd0;
    localparam logic [3:0] TK_ERROR  = 4'd1;
    localparam logic [3:0] TK_STRING = 4'd2;
    localparam logic [3:0] TK_NUMBER = 4'd3;
    localparam logic [3:0] TK_TRUE   = 4'd4;
    localparam logic [3:0] TK_FALSE  = 4'd5;
    localparam logic [3:0] TK_NULL   = 4'd6;
    localparam logic [3:0] TK_LBRACE = 4'd7;
    localparam logic [3:0] TK_RBRACE = 4'd8;
    localparam logic [3:0] TK_LBRACK = 4'd9;
    localparam logic [3:0] TK_RBRACK = 4'd10;
    localparam logic [3:0] TK_COMMA  = 4'd11;
    localparam logic [3:0] TK_COLON  = 4'd12;

    localparam logic [1:0] KW_NONE  = 2'd0;
    localparam logic [1:0] KW_TRUE  = 2'd1;
    localparam logic [1:0] KW_FALSE = 2'd2;
    localparam logic [1:0] KW_NULL  = 2'd3;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // up to three tokens caused by one input byte
    localparam int MAX_TOKENS = 3;

    typedef struct packed {
        logic [1:0]                  count;
        logic [MAX_TOKENS-1:0][3:0]  kinds;
        logic [15:0]                 value_start;   // first token only
        logic [15:0]                 value_length;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // what a byte does when scanned between tokens
    typedef enum logic [2:0] {
        ACT_SKIP,
        ACT_EMIT,
        ACT_STRING,
        ACT_NUMBER,
        ACT_KEYWORD,
        ACT_ERROR
    } idle_act_t;

    typedef struct packed {
        idle_act_t  act;
        logic [3:0] kind;
        logic [1:0] kw;
    } idle_class_t;

    function automatic idle_class_t idle_classify(input logic [7:0] c);
        idle_class_t r;
        r.act  = ACT_ERROR;
        r.kind = TK_ERROR;
        r.kw   = KW_NONE;
        if (c == CH_QUOTE) begin
            r.act = ACT_STRING;
        end else if (c inside {["0":"9"], "-", "+", "."}) begin
            r.act = ACT_NUMBER;
        end else if (c inside {"t", "T"}) begin
            r.act = ACT_KEYWORD;
            r.kw  = KW_TRUE;
        end else if (c inside {"f", "F"}) begin
            r.act = ACT_KEYWORD;
            r.kw  = KW_FALSE;
        end else if (c == "n") begin
            r.act = ACT_KEYWORD;
            r.kw  = KW_NULL;
        end else if (c == "{") begin
            r.act  = ACT_EMIT;
            r.kind = TK_LBRACE;
        end else if (c == "}") begin
            r.act  = ACT_EMIT;
            r.kind = TK_RBRACE;
        end else if (c == "[") begin
            r.act  = ACT_EMIT;
            r.kind = TK_LBRACK;
        end else if (c == "]") begin
            r.act  = ACT_EMIT;
            r.kind = TK_RBRACK;
        end else if (c == ",") begin
            r.act  = ACT_EMIT;
            r.kind = TK_COMMA;
        end else if (c == ":") begin
            r.act  = ACT_EMIT;
            r.kind = TK_COLON;
        end else if (c inside {" ", [8'h09:8'h0D]}) begin
            r.act = ACT_SKIP;
        end
        return r;
    endfunction

    function automatic logic num_continues(input logic [7:0] c);
        return c inside {["0":"9"], ["A":"Z"], ["a":"z"], "+", "-", "."};
    endfunction

    // letters after the first one: rue, alse, ull
    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] r;
        case (k)
            KW_TRUE:  r = 3'd3;
            KW_FALSE: r = 3'd4;
            KW_NULL:  r = 3'd3;
            default:  r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] m);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            KW_TRUE: begin
                case (m)
                    3'd0:    r = "r";
                    3'd1:    r = "u";
                    3'd2:    r = "e";
                    default: r = 8'h00;
                endcase
            end
            KW_FALSE: begin
                case (m)
                    3'd0:    r = "a";
                    3'd1:    r = "l";
                    3'd2:    r = "s";
                    3'd3:    r = "e";
                    default: r = 8'h00;
                endcase
            end
            KW_NULL: begin
                case (m)
                    3'd0:    r = "u";
                    3'd1:    r = "l";
                    3'd2:    r = "l";
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] kw_token(input logic [1:0] k);
        logic [3:0] r;
        case (k)
            KW_TRUE:  r = TK_TRUE;
            KW_FALSE: r = TK_FALSE;
            KW_NULL:  r = TK_NULL;
            default:  r = TK_ERROR;
        endcase
        return r;
    endfunction

endpackage

// ----- src/jbt_front.sv -----
// Front scanner: accepts one byte per beat, tracks lexer state and
// pushes the tokens each byte causes as one bundle. Depends on jbt_pkg.
module jbt_front
    import jbt_pkg::*;
#(
    parameter int MAX_BUFFER_BYTES = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_stall,
    input  byte_beat_t byte_beat,
    output push_t      push
);

    localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BUFFER_BYTES);

    typedef enum logic [5:0] {
        M_IDLE    = 6'b000001,
        M_STRING  = 6'b000010,
        M_ESCAPE  = 6'b000100,
        M_NUMBER  = 6'b001000,
        M_KEYWORD = 6'b010000,
        M_DROP    = 6'b100000
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [1:0]       kw_kind_reg, kw_kind_next;
    logic [2:0]       kw_match_reg, kw_match_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] tstart_reg, tstart_next;

    logic                       accept;
    logic [1:0]                 cnt;
    logic [MAX_TOKENS-1:0][3:0] kinds;
    logic [15:0]                vstart, vlen;
    logic                       run_idle;
    idle_class_t                cls;
    logic [7:0]                 c;

    assign accept = byte_valid && !byte_stall;
    assign c      = byte_beat.data_byte;

    always_comb
    begin
        mode_next     = mode_reg;
        kw_kind_next  = kw_kind_reg;
        kw_match_next = kw_match_reg;
        pos_next      = pos_reg;
        tstart_next   = tstart_reg;
        cnt           = 2'd0;
        kinds         = '0;
        vstart        = 16'd0;
        vlen          = 16'd0;
        run_idle      = 1'b0;
        cls           = idle_classify(c);

        if (pos_reg >= POS_MAX) begin
            if (mode_reg != M_DROP) begin
                kinds[cnt] = TK_ERROR;
                cnt        = cnt + 2'd1;
                mode_next  = M_DROP;
            end
        end else begin
            case (mode_reg)
                M_IDLE: run_idle = 1'b1;
                M_STRING: begin
                    if (c == CH_BACKSLASH) begin
                        mode_next = M_ESCAPE;
                    end else if (c == CH_QUOTE) begin
                        if (byte_beat.buffer_end) begin
                            kinds[cnt] = TK_ERROR;
                            mode_next  = M_DROP;
                        end else begin
                            kinds[cnt] = TK_STRING;
                            vstart     = 16'(tstart_reg);
                            vlen       = 16'(pos_reg - tstart_reg);
                            mode_next  = M_IDLE;
                        end
                        cnt = cnt + 2'd1;
                    end
                end
                M_ESCAPE: mode_next = M_STRING;
                M_NUMBER: begin
                    if (!num_continues(c)) begin
                        kinds[cnt] = TK_NUMBER;
                        vstart     = 16'(tstart_reg);
                        vlen       = 16'(pos_reg - tstart_reg);
                        cnt        = cnt + 2'd1;
                        mode_next  = M_IDLE;
                        run_idle   = 1'b1;
                    end
                end
                M_KEYWORD: begin
                    if (kw_kind_reg == KW_NONE || kw_match_reg >= kw_len(kw_kind_reg)
                        || c != kw_char(kw_kind_reg, kw_match_reg)) begin
                        kinds[cnt] = TK_ERROR;
                        cnt        = cnt + 2'd1;
                        mode_next  = M_DROP;
                    end else begin
                        kw_match_next = kw_match_reg + 3'd1;
                        if (kw_match_next == kw_len(kw_kind_reg)) begin
                            if (byte_beat.buffer_end) begin
                                kinds[cnt] = TK_ERROR;
                                mode_next  = M_DROP;
                            end else begin
                                kinds[cnt] = kw_token(kw_kind_reg);
                                mode_next  = M_IDLE;
                            end
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (run_idle) begin
            case (cls.act)
                ACT_STRING: begin
                    mode_next   = M_STRING;
                    tstart_next = pos_reg + POS_W'(1);
                end
                ACT_NUMBER: begin
                    mode_next   = M_NUMBER;
                    tstart_next = pos_reg;
                end
                ACT_KEYWORD: begin
                    mode_next     = M_KEYWORD;
                    kw_kind_next  = cls.kw;
                    kw_match_next = 3'd0;
                end
                ACT_EMIT: begin
                    kinds[cnt] = cls.kind;
                    cnt        = cnt + 2'd1;
                end
                ACT_ERROR: begin
                    kinds[cnt] = TK_ERROR;
                    cnt        = cnt + 2'd1;
                    mode_next  = M_DROP;
                end
                default: ;
            endcase
        end

        if (byte_beat.buffer_end) begin
            if (mode_next == M_IDLE) begin
                kinds[cnt] = TK_END;
                cnt        = cnt + 2'd1;
            end else if (mode_next != M_DROP) begin
                kinds[cnt] = TK_ERROR;
                cnt        = cnt + 2'd1;
            end
            // next buffer starts from reset state
            mode_next     = M_IDLE;
            kw_kind_next  = KW_NONE;
            kw_match_next = 3'd0;
            pos_next      = '0;
            tstart_next   = '0;
        end else if (pos_reg < POS_MAX) begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= M_IDLE;
            kw_kind_reg  <= KW_NONE;
            kw_match_reg <= 3'd0;
            pos_reg      <= '0;
            tstart_reg   <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            kw_kind_reg  <= kw_kind_next;
            kw_match_reg <= kw_match_next;
            pos_reg      <= pos_next;
            tstart_reg   <= tstart_next;
        end
    end

    always_comb
    begin
        push.valid               = accept && (cnt != 2'd0);
        push.bundle.count        = cnt;
        push.bundle.kinds        = kinds;
        push.bundle.value_start  = vstart;
        push.bundle.value_length = vlen;
    end

endmodule

// ----- src/jbt_queue.sv -----
// Short bundle queue between the scanner and the token emitter.
// Depends on jbt_pkg.
module jbt_queue
    import jbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    input  logic      pop,
    output bundle_t   head,
    output q_status_t status
);

    bundle_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push      = push.valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push.bundle;
        end
    end

endmodule

// ----- src/jbt_back.sv -----
// Token emitter: walks each queued bundle one token per beat into the
// output register. Depends on jbt_pkg.
module jbt_back
    import jbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bundle_t     head,
    input  q_status_t   status,
    output logic        pop,
    output logic        token_valid,
    input  logic        token_stall,
    output token_beat_t token_beat
);

    logic        out_valid_reg, out_valid_next;
    token_beat_t out_reg, out_next;
    logic [1:0]  idx_reg, idx_next;
    logic        load, last;

    assign load = !status.empty && (!out_valid_reg || !token_stall);
    assign last = (idx_reg == head.count - 2'd1);
    assign pop  = load && last;

    always_comb
    begin
        out_next.token_kind   = head.kinds[idx_reg];
        out_next.value_start  = (idx_reg == 2'd0) ? head.value_start : 16'd0;
        out_next.value_length = (idx_reg == 2'd0) ? head.value_length : 16'd0;
        out_next.last_of_run  = last;

        idx_next = idx_reg;
        if (load) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end

        if (load) begin
            out_valid_next = 1'b1;
        end else if (token_stall) begin
            out_valid_next = out_valid_reg;
        end else begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_reg <= out_next;
        end
    end

    assign token_valid = out_valid_reg;
    assign token_beat  = out_reg;

endmodule

// ----- src/json_byte_tokenizer_core.sv -----
// JSON byte tokenizer, top level.
// Input channel (byte_valid / byte_stall / byte_beat): one byte of JSON text
// per beat, buffer_end set on the last byte of a buffer.
// Output channel (token_valid / token_stall / token_beat): one token per
// beat; last_of_run marks the final token caused by an input byte.
// Throughput: one byte per cycle while each byte causes at most one token
// and token_stall stays low. A byte causing n tokens (n up to 3) has them
// sent one at a time; the one-token-per-cycle emitter is the limit.
// A byte's bundle is first written into the queue, and its first token is
// then loaded from there into the output register.
// A four-entry bundle queue sits between the scanner and the emitter;
// byte_stall rises only when that queue is full, so bytes keep flowing
// while a token waits on token_stall.
// Reset clears the lexer state, the queue and the output valid; the block
// is ready for a byte in the first cycle after reset.
// Lexer state returns to reset values after every byte flagged buffer_end.
// Depends on jbt_pkg, jbt_front, jbt_queue, jbt_back.
module json_byte_tokenizer_core
    import jbt_pkg::*;
#(
    parameter int MAX_BUFFER_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  byte_beat_t  byte_beat,
    output logic        token_valid,
    input  logic        token_stall,
    output token_beat_t token_beat
);

    push_t     push;
    bundle_t   head;
    q_status_t status;
    logic      pop;

    assign byte_stall = status.full;

    jbt_front #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_beat  (byte_beat),
        .push       (push)
    );

    jbt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (status)
    );

    jbt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .status      (status),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_beat  (token_beat)
    );

endmodule

// ----- src/jbt_checker.sv -----
// Port-level checks for the JSON byte tokenizer, bound to the top level.
// Depends on jbt_pkg and json_byte_tokenizer_core_macros.svh.
`include "json_byte_tokenizer_core_macros.svh"

module jbt_checker
    import jbt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input byte_beat_t  byte_beat,
    input logic        token_valid,
    input logic        token_stall,
    input token_beat_t token_beat
);

    logic no_value;
    assign no_value = (token_beat.token_kind != TK_STRING)
                      && (token_beat.token_kind != TK_NUMBER);

    `JBT_ASSERT_NXT(a_in_hold, byte_valid && byte_stall, byte_valid && $stable(byte_beat), "stalled byte beat changed")
    `JBT_ASSERT_NXT(a_out_hold, token_valid && token_stall, token_valid && $stable(token_beat), "stalled token beat changed")
    `JBT_ASSERT_IMP(a_kind_range, token_valid, token_beat.token_kind <= TK_COLON, "token kind out of range")
    `JBT_ASSERT_IMP(a_no_value, token_valid && no_value, token_beat.value_start == 16'd0 && token_beat.value_length == 16'd0, "value fields set on a plain token")
    `JBT_ASSERT_IMP(a_end_last, token_valid && token_beat.token_kind == TK_END, token_beat.last_of_run, "end token not last of its run")

endmodule

bind json_byte_tokenizer_core jbt_checker u_jbt_checker (.*);
